FILE: rtl/pdfa_pkg.sv
// ----------------------------------------------------------------------------
// pdfa_pkg
// Shared types, constants and tables of the path discount factor accumulator.
// ----------------------------------------------------------------------------
package pdfa_pkg;

	// default number of terms with a running sum
	localparam int MAX_TERMS_DEF = 64;

	localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
	localparam logic [31:0] U32_MAX  = 32'hFFFF_FFFF;
	localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam logic [34:0] LN2_Q30  = 35'd744261118;

	// exponent magnitude limits: at or above 2*ln2 a positive exponent saturates,
	// above 31*ln2 a negative exponent underflows to zero
	localparam logic [41:0] A_SAT_LIM  = 42'd1488522236;
	localparam logic [41:0] A_ZERO_LIM = 42'd23072094658;

	localparam logic [3:0] TAYLOR_LAST = 4'd12;

	// divider dividend width: 48-bit sum plus rounding half
	localparam int DIV_W = 49;

	typedef struct packed {
		logic signed [31:0] rate;
		logic [31:0]        term_time;
		logic [5:0]         term_index;
		logic               final_path;
	} in_word_t;

	typedef struct packed {
		logic [31:0] discount;
		logic [5:0]  term_echo;
		logic        price_valid;
		logic [31:0] zero_price;
	} out_word_t;

	// request to the exponential unit
	typedef struct packed {
		logic        start;
		logic        pos;    // exponent is +mag when set, -mag otherwise
		logic [41:0] mag;    // exponent magnitude, Q.30
	} exp_req_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_RED,
		EX_SETUP,
		EX_MUL,
		EX_REC,
		EX_ACC,
		EX_FIN
	} exp_state_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAG0,
		ST_MAG1,
		ST_MAG2,
		ST_MAG3,
		ST_EXPS,
		ST_EXPW,
		ST_DF0,
		ST_DF1,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} core_state_t;

	// reciprocal multiplier for exact floor(v / i), v < 2^30:
	// m = ceil(2^(30+l) / i), l = ceil(log2 i)
	function automatic logic [30:0] recip_mult(input logic [3:0] i);
		logic [30:0] m;
		case (i)
			4'd3:    m = 31'd1431655766;
			4'd5:    m = 31'd1717986919;
			4'd6:    m = 31'd1431655766;
			4'd7:    m = 31'd1227133514;
			4'd9:    m = 31'd1908874354;
			4'd10:   m = 31'd1717986919;
			4'd11:   m = 31'd1561806290;
			4'd12:   m = 31'd1431655766;
			default: m = 31'h4000_0000;
		endcase
		return m;
	endfunction

	// matching right shift, 30 + l
	function automatic logic [5:0] recip_shift(input logic [3:0] i);
		logic [5:0] s;
		case (i)
			4'd2:                          s = 6'd31;
			4'd3, 4'd4:                    s = 6'd32;
			4'd5, 4'd6, 4'd7, 4'd8:        s = 6'd33;
			4'd9, 4'd10, 4'd11, 4'd12:     s = 6'd34;
			default:                       s = 6'd30;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/path_discount_factor_accumulator_core.sv
// ----------------------------------------------------------------------------
// path_discount_factor_accumulator_core
// Running discount factor per path with trapezoidal rate integration, per-term
// sums in a synchronous memory, and zero-coupon price output on the last path.
// ----------------------------------------------------------------------------
//  channel | signals                              | word
//  --------+--------------------------------------+---------------------------
//  in      | in_valid, in_stall, in_data          | rate, time, index, final
//  out     | out_valid, out_stall, out_data       | discount, echo, price
//  cfg     | cfg_valid, cfg_ready, cfg_data       | path_count
//
//  One word at a time. Term 0 goes straight to the sum update. Later terms
//  run the exp unit (5 reduction steps, 12 Taylor steps of multiply, divide
//  and add), which skips them when the exponent saturates or underflows. A
//  final-path word at a later term adds the bit-serial price divider. Output
//  stalls add. After reset the term sum memory is cleared entry by entry;
//  in_stall stays high meanwhile. cfg_ready is always high. The output
//  register holds a finished word while the next one is taken in.
// ----------------------------------------------------------------------------
module path_discount_factor_accumulator_core #(
	parameter int MAX_TERMS = pdfa_pkg::MAX_TERMS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pdfa_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output pdfa_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import pdfa_pkg::*;

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	core_state_t state_q, state_d;

	logic [47:0] mem [MAX_TERMS];

	in_word_t    in_q;
	logic        in_rng_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic [31:0] last_rate_q;
	logic [31:0] last_time_q;
	logic [31:0] df_q;
	logic [15:0] pc_q;
	logic [47:0] rd_q;
	logic [32:0] abs_s_q;
	logic [31:0] dt_q;
	logic        pos_q;
	logic [48:0] pp0_q;
	logic [48:0] pp1_q;
	logic [41:0] mag_q;
	logic [63:0] dfp_q;
	logic [31:0] price_q;
	logic        pvalid_q;
	logic        out_valid_q;
	out_word_t   out_q;

	logic        accept;
	logic        out_free;
	logic [32:0] s_sum;
	logic [64:0] mag_full;
	logic [48:0] sm_full;
	logic [47:0] sm_sat;
	logic [15:0] pc_eff;
	logic        fin_here;
	logic        mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [47:0] mem_wd;
	exp_req_t    exp_req;
	logic        exp_done;
	logic [31:0] exp_res;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_res;

	// handshakes
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// arithmetic helpers
	always_comb begin
		s_sum    = $signed({last_rate_q[31], last_rate_q})
			+ $signed({in_q.rate[31], in_q.rate});
		mag_full = {16'b0, pp0_q} + {pp1_q, 16'b0} + 65'(23'h40_0000);
		sm_full  = {1'b0, rd_q} + {17'b0, df_q};
		sm_sat   = sm_full[48] ? SUM_MAX : sm_full[47:0];
		pc_eff   = (pc_q == '0) ? 16'd1 : pc_q;
		fin_here = in_q.final_path && in_rng_q;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory write port, unit starts
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wa    = idx_q;
		mem_wd    = '0;
		div_start = 1'b0;
		exp_req   = '{start: 1'b0, pos: pos_q, mag: mag_q};
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				if (clr_cnt_q == IDX_W'(MAX_TERMS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_data.term_index == '0) ? ST_SUM : ST_MAG0;
				end
			end
			ST_MAG0: state_d = ST_MAG1;
			ST_MAG1: state_d = ST_MAG2;
			ST_MAG2: state_d = ST_MAG3;
			ST_MAG3: state_d = ST_EXPS;
			ST_EXPS: begin
				exp_req.start = 1'b1;
				state_d       = ST_EXPW;
			end
			ST_EXPW: if (exp_done) state_d = ST_DF0;
			ST_DF0:  state_d = ST_DF1;
			ST_DF1:  state_d = ST_SUM;
			ST_SUM: begin
				mem_we = in_rng_q;
				mem_wd = in_q.final_path ? '0 : sm_sat;
				if (fin_here && in_q.term_index != '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: if (div_done) state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// term sum memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (accept) rd_q <= mem[IDX_W'(in_data.term_index)];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			pc_q        <= 16'd1;
			last_rate_q <= '0;
			last_time_q <= '0;
			df_q        <= ONE_Q30;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cfg_valid && cfg_ready) pc_q <= cfg_data;
			if (accept && in_data.term_index == '0) df_q <= ONE_Q30;
			if (state_q == ST_DF1) begin
				df_q <= (dfp_q[63:62] != 2'b00) ? U32_MAX : dfp_q[61:30];
			end
			if (state_q == ST_SUM) begin
				last_rate_q <= in_q.rate;
				last_time_q <= in_q.term_time;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q     <= in_data;
			idx_q    <= IDX_W'(in_data.term_index);
			in_rng_q <= (int'(in_data.term_index) < MAX_TERMS);
		end
		case (state_q)
			ST_MAG0: begin
				abs_s_q <= s_sum[32] ? 33'(-s_sum) : s_sum;
				pos_q   <= s_sum[32];
				dt_q    <= (in_q.term_time >= last_time_q)
					? (in_q.term_time - last_time_q) : '0;
			end
			ST_MAG1: pp0_q <= 49'(abs_s_q) * 49'(dt_q[15:0]);
			ST_MAG2: pp1_q <= 49'(abs_s_q) * 49'(dt_q[31:16]);
			ST_MAG3: mag_q <= mag_full[64:23];
			ST_DF0:  dfp_q <= 64'(df_q) * 64'(exp_res);
			ST_SUM: begin
				pvalid_q <= fin_here;
				price_q  <= (fin_here && in_q.term_index == '0) ? ONE_Q30 : '0;
			end
			ST_DIV:  if (div_done) price_q <= div_res;
			ST_OUT: begin
				if (out_free) begin
					out_q.discount    <= df_q;
					out_q.term_echo   <= in_q.term_index;
					out_q.price_valid <= pvalid_q;
					out_q.zero_price  <= price_q;
				end
			end
			default: ;
		endcase
	end

	pdfa_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (exp_req),
		.done   (exp_done),
		.result (exp_res)
	);

	pdfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({1'b0, sm_sat} + {33'b0, 1'b0, pc_eff[15:1]}),
		.divisor  (pc_eff),
		.done     (div_done),
		.quotient (div_res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// price only for terms that have a sum
	a_price_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.price_valid |-> int'(out_q.term_echo) < MAX_TERMS)
		else $error("price for a term without a sum");

	a_price_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.price_valid |-> out_q.zero_price == '0)
		else $error("zero_price set without price_valid");

	a_term0_price: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.price_valid && out_q.term_echo == '0
			|-> out_q.zero_price == ONE_Q30 && out_q.discount == ONE_Q30)
		else $error("term 0 price or discount not one");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("second word taken while one is in work");

endmodule

FILE: rtl/pdfa_exp.sv
// ----------------------------------------------------------------------------
// pdfa_exp
// Sequential exp() in Q2.30: range reduction by ln2, 13-term Taylor series
// with one shared multiplier pair, then scaling by 2^k.
// ----------------------------------------------------------------------------
module pdfa_exp (
	input  logic              clk,
	input  logic              arst_n,
	input  pdfa_pkg::exp_req_t req,
	output logic              done,
	output logic [31:0]       result
);
	import pdfa_pkg::*;

	exp_state_t  state_q, state_d;
	logic [34:0] rem_q;
	logic        pos_q;
	logic [4:0]  quo_q;
	logic [2:0]  bit_q;
	logic [29:0] f_q;
	logic        left_q;
	logic [4:0]  sh_q;
	logic [30:0] term_q;
	logic [32:0] sum_q;
	logic [3:0]  i_q;
	logic [60:0] prod_q;
	logic [60:0] est_q;
	logic [31:0] result_q;
	logic        done_q;

	logic [35:0] trial;
	logic        rem_nz;
	logic [29:0] f_neg;
	logic [30:0] qv;
	logic [33:0] scaled;

	// datapath helpers
	always_comb begin
		trial  = {1'b0, rem_q} - ({1'b0, LN2_Q30} << bit_q);
		rem_nz = (rem_q != '0);
		f_neg  = rem_nz ? 30'(LN2_Q30 - rem_q) : '0;
		qv     = 31'(est_q >> recip_shift(i_q));
		scaled = left_q ? {sum_q, 1'b0} : {1'b0, sum_q >> sh_q};
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			EX_IDLE: begin
				if (req.start && !(req.pos && req.mag >= A_SAT_LIM)
						&& !(!req.pos && req.mag > A_ZERO_LIM)) begin
					state_d = EX_RED;
				end
			end
			EX_RED:   if (bit_q == 3'd0) state_d = EX_SETUP;
			EX_SETUP: state_d = EX_MUL;
			EX_MUL:   state_d = EX_REC;
			EX_REC:   state_d = EX_ACC;
			EX_ACC:   state_d = (i_q == TAYLOR_LAST) ? EX_FIN : EX_MUL;
			EX_FIN:   state_d = EX_IDLE;
			default:  state_d = EX_IDLE;
		endcase
	end

	// control: done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == EX_FIN) || (state_q == EX_IDLE && req.start
				&& state_d == EX_IDLE);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			EX_IDLE: begin
				pos_q <= req.pos;
				rem_q <= req.mag[34:0];
				quo_q <= '0;
				bit_q <= 3'd4;
				if (req.start) begin
					result_q <= req.pos ? U32_MAX : '0;
				end
			end
			EX_RED: begin
				if (!trial[35]) begin
					rem_q        <= trial[34:0];
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 3'd1;
			end
			EX_SETUP: begin
				if (pos_q) begin
					f_q    <= rem_q[29:0];
					left_q <= quo_q[0];
					sh_q   <= '0;
				end else begin
					f_q    <= f_neg;
					left_q <= 1'b0;
					sh_q   <= quo_q + 5'(rem_nz);
				end
				term_q <= 31'(ONE_Q30);
				sum_q  <= 33'(ONE_Q30);
				i_q    <= 4'd1;
			end
			EX_MUL: prod_q <= 61'(term_q) * 61'(f_q);
			EX_REC: est_q  <= 61'(prod_q[59:30]) * 61'(recip_mult(i_q));
			EX_ACC: begin
				term_q <= qv;
				sum_q  <= sum_q + 33'(qv);
				i_q    <= i_q + 4'd1;
			end
			EX_FIN: result_q <= (scaled[33:32] != 2'b00) ? U32_MAX : scaled[31:0];
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/pdfa_div.sv
// ----------------------------------------------------------------------------
// pdfa_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module pdfa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pdfa_pkg::DIV_W-1:0] dividend,
	input  logic [15:0]               divisor,
	output logic                      done,
	output logic [31:0]               quotient
);
	import pdfa_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      rem_q;
	logic [15:0]      dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [31:0]      res_q;

	logic [16:0]      shifted;
	logic             take;
	logic [DIV_W-1:0] quo_next;

	// one restoring step
	always_comb begin
		shifted  = {rem_q, quo_q[DIV_W-1]};
		take     = (shifted >= {1'b0, dvs_q});
		quo_next = {quo_q[DIV_W-2:0], take};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) busy_q <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
			quo_q <= quo_next;
			if (cnt_q == '0) begin
				res_q <= (quo_next[DIV_W-1:32] != '0) ? U32_MAX : quo_next[31:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = res_q;

	// a finished division is always preceded by a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != '0 |-> !start)
		else $error("divider restarted while busy");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(start) |-> rem_q < dvs_q)
		else $error("divider remainder out of range");

endmodule

FILE: test/path_discount_factor_accumulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_discount_factor_accumulator_core_tb
// Drives rate samples path by path with random idling on both channels and
// checks every output word against a discount factor and price predictor.
// ----------------------------------------------------------------------------
module path_discount_factor_accumulator_core_tb;
	import pdfa_pkg::*;

	localparam int    N_TERMS   = 64;
	localparam longint LN2      = 744261118;
	localparam int    CYCLE_CAP = 2000000;

	// discount predictor state and expected output words
	class df_scoreboard;
		bit [15:0] paths;
		bit [31:0] prev_rate;
		bit [31:0] prev_time;
		bit [31:0] df;
		bit [47:0] sums [N_TERMS];
		out_word_t pending [$];
		int        mismatches;
		int        checked;

		function void clear_state();
			prev_rate = '0;
			prev_time = '0;
			df = ONE_Q30;
			foreach (sums[i]) sums[i] = '0;
		endfunction

		function bit [31:0] exp_q30(longint x);
			longint k, m, q, rm;
			bit [63:0] f, t, acc;
			if (x >= 0) begin
				k = x / LN2;
				f = x - k * LN2;
			end else begin
				m = -x;
				q = m / LN2;
				rm = m - q * LN2;
				k = -q;
				if (rm != 0) begin
					k = k - 1;
					f = LN2 - rm;
				end else
					f = 0;
			end
			t = 64'h4000_0000;
			acc = t;
			for (int i = 1; i <= 12; i++) begin
				t = ((t * f) >> 30) / i;
				acc += t;
			end
			if (k >= 2) return 32'hFFFF_FFFF;
			if (k == 1) acc = acc << 1;
			if (k >= 0) return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
			if (-k >= 32) return 0;
			return acc >> (-k);
		endfunction

		// note an accepted input word
		function void note_sample(in_word_t w);
			longint s, a;
			bit [63:0] dt, mg, p, sm, pc;
			out_word_t e;
			e = '0;
			if (w.term_index == 0)
				df = ONE_Q30;
			else begin
				s = longint'($signed(prev_rate)) + longint'($signed(w.rate));
				dt = (w.term_time >= prev_time) ? w.term_time - prev_time : 0;
				mg = (s < 0 ? -s : s) * dt;
				a = (mg + (64'd1 << 22)) >> 23;
				p = (64'(df) * 64'(exp_q30(s >= 0 ? -a : a))) >> 30;
				df = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
			end
			prev_rate = w.rate;
			prev_time = w.term_time;
			sm = 64'(sums[w.term_index]) + df;
			if (sm > 64'hFFFF_FFFF_FFFF) sm = 64'hFFFF_FFFF_FFFF;
			sums[w.term_index] = sm[47:0];
			if (w.final_path) begin
				pc = (paths == 0) ? 1 : paths;
				e.price_valid = 1'b1;
				if (w.term_index == 0)
					e.zero_price = ONE_Q30;
				else begin
					p = (sm + pc / 2) / pc;
					e.zero_price = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
				end
				sums[w.term_index] = '0;
			end
			e.discount = df;
			e.term_echo = w.term_index;
			pending.push_back(e);
		endfunction

		// compare one output word with the oldest expectation
		function void check_word(out_word_t got);
			out_word_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word %h", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp df=%h idx=%0d pv=%b zp=%h got df=%h idx=%0d pv=%b zp=%h",
						e.discount, e.term_echo, e.price_valid, e.zero_price,
						got.discount, got.term_echo, got.price_valid, got.zero_price);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [15:0] cfg_data = '0;

	df_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;
	int prices = 0;

	path_discount_factor_accumulator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("[path_discount_factor_accumulator_core] ERROR");
			$finish;
		end
	end

	// output side: check accepted words, random stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_word(out_data);
				if (out_data.price_valid) prices++;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// send one word, idling at random beforehand; valid stays up after the
	// accepting edge until the next send or an explicit drop
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (in_stall);
		sb.note_sample(w);
	endtask

	// register write while idle
	task automatic write_paths(bit [15:0] v);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.paths = v;
	endtask

	function automatic in_word_t mk(bit [31:0] r, bit [31:0] t, bit [5:0] i, bit f);
		in_word_t w;
		w.rate = r;
		w.term_time = t;
		w.term_index = i;
		w.final_path = f;
		return w;
	endfunction

	// random rate: mostly realistic, sometimes full range
	function automatic bit [31:0] rnd_rate();
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(80_000_000)) - 32'sd20_000_000;
	endfunction

	// one price run: npaths paths of nterms terms, last path flagged final
	task automatic run_prices(int npaths, int nterms, ref int budget);
		bit [31:0] t;
		for (int p = 0; p < npaths; p++) begin
			t = 0;
			for (int i = 0; i < nterms; i++) begin
				if (budget <= 0) return;
				if ($urandom_range(19) == 0) t = $urandom;
				else if (i > 0) t = t + $urandom_range(1 << 25);
				send_word(mk(rnd_rate(), t,
					($urandom_range(29) == 0) ? 6'($urandom) : 6'(i),
					(p == npaths - 1) || ($urandom_range(49) == 0)));
				budget--;
			end
		end
	endtask

	initial begin
		int budget;
		int np, nt;
		sb = new();
		sb.paths = 1;
		sb.clear_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, backward time, out of order, final path at term 0
		send_word(mk(32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1'b1));
		send_word(mk(32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd1, 1'b0));
		send_word(mk(32'h8000_0000, 32'h0000_0000, 6'd2, 1'b0));
		send_word(mk(32'h8000_0000, 32'h0100_0000, 6'd3, 1'b1));
		send_word(mk(32'h8000_0000, 32'hFFFF_FFFF, 6'd4, 1'b1));
		send_word(mk(32'h8000_0000, 32'hFFFF_FFFF, 6'd63, 1'b1));
		send_word(mk(32'h0000_0000, 32'h0000_0000, 6'd0, 1'b0));
		send_word(mk(32'h7FFF_FFFF, 32'h0200_0000, 6'd7, 1'b0));
		send_word(mk(32'h0500_0000, 32'h0100_0000, 6'd5, 1'b1));
		send_word(mk(32'h0100_0000, 32'h0180_0000, 6'd63, 1'b1));
		write_paths(16'd0);
		send_word(mk(32'hFFFF_FFFF, 32'h0000_0000, 6'd0, 1'b0));
		send_word(mk(32'h0100_0000, 32'h0100_0000, 6'd1, 1'b1));
		write_paths(16'hFFFF);
		send_word(mk(32'h0, 32'h0, 6'd0, 1'b1));
		send_word(mk(32'h0100_0000, 32'h0100_0000, 6'd1, 1'b1));
		write_paths(16'd3);
		for (int p = 0; p < 3; p++)
			for (int i = 0; i < 3; i++)
				send_word(mk(32'h0200_0000 + p, 32'(i) << 24, 6'(i), p == 2));

		// random phases: mostly receiver idling first, then mostly sender idling, then neither
		budget = 1300;
		for (int ph = 0; budget > 0; ph++) begin
			if (budget > 867) begin
				send_idle_pct = 23;
				recv_idle_pct = 70;
			end else if (budget > 433) begin
				send_idle_pct = 70;
				recv_idle_pct = 23;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			np = $urandom_range(1, 6);
			nt = ($urandom_range(9) == 0) ? 64 : $urandom_range(2, 12);
			write_paths((ph % 7 == 3) ? 16'($urandom) : 16'(np));
			run_prices(np, nt, budget);
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		$display("checked %0d output words, %0d of them with a price",
			sb.checked, prices);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[path_discount_factor_accumulator_core] OK");
		else
			$display("[path_discount_factor_accumulator_core] ERROR");
		$finish;
	end
endmodule

FILE: path_discount_factor_accumulator_core.f
rtl/pdfa_pkg.sv
rtl/pdfa_exp.sv
rtl/pdfa_div.sv
rtl/path_discount_factor_accumulator_core.sv
test/path_discount_factor_accumulator_core_tb.sv
